FILE: design/julian_day_number_converter_top_defines.svh
// assertion macros for the julian day number converter
`ifndef JULIAN_DAY_NUMBER_CONVERTER_TOP_DEFINES_SVH
`define JULIAN_DAY_NUMBER_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define JDNC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define JDNC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/jdnc_pkg.sv
// constants and lookup tables for the julian day number converter
package jdnc_pkg;

   localparam int NumStages = 9;

   localparam logic [22:0] GregLastJul = 23'd2299160;
   localparam int GregFirstJdn = 2299161;
   localparam int GregOffset   = 32045;
   localparam int JulOffset    = 32083;
   localparam int GregShift    = 32044;
   localparam int JulShift     = 32082;
   localparam int YearBias     = 4800;
   localparam int DaysPer400   = 146097;
   localparam int DaysPer4     = 1461;

   // floor(q / 25) through a biased reciprocal, bias keeps the dividend positive
   localparam int Q100Bias     = 128;
   localparam int Q400Bias     = 32;
   localparam logic [12:0] Recip25 = 13'd5243;
   localparam int Recip25Shift = 17;

   // reciprocals, shifts 44, 34 and 18
   localparam logic [26:0] Recip146097 = 27'd120414424;
   localparam logic [23:0] Recip1461   = 24'd11758980;
   localparam logic [10:0] Recip153    = 11'd1714;

   // floor((153 * k + 2) / 5), days from 1 march to the start of month k
   function automatic logic [8:0] mar_offset(input logic [3:0] k);
      logic [8:0] r;
      unique case (k)
         4'd0:  r = 9'd0;
         4'd1:  r = 9'd31;
         4'd2:  r = 9'd61;
         4'd3:  r = 9'd92;
         4'd4:  r = 9'd122;
         4'd5:  r = 9'd153;
         4'd6:  r = 9'd184;
         4'd7:  r = 9'd214;
         4'd8:  r = 9'd245;
         4'd9:  r = 9'd275;
         4'd10: r = 9'd306;
         4'd11: r = 9'd337;
         4'd12: r = 9'd367;
         4'd13: r = 9'd398;
         4'd14: r = 9'd428;
         default: r = 9'd459;
      endcase
      return r;
   endfunction

   // month counted from march, also for month codes outside 1 to 12
   function automatic logic [3:0] month_to_mar(input logic [3:0] m);
      logic [3:0] r;
      priority if (m <= 4'd2) r = m + 4'd9;
      else if (m == 4'd15) r = 4'd0;
      else r = m - 4'd3;
      return r;
   endfunction

   // 4800 minus one for jan and feb (and month code 0), plus one for month code 15
   function automatic logic [12:0] year_bias(input logic [3:0] m);
      logic [12:0] r;
      priority if (m <= 4'd2) r = 13'(YearBias - 1);
      else if (m == 4'd15) r = 13'(YearBias + 1);
      else r = 13'(YearBias);
      return r;
   endfunction

endpackage

FILE: design/julian_day_number_converter_top.sv
// an accepted item moves through the register stages s1 to s9 to the result
// throughput: one item per cycle while the result is taken, set by the fully pipelined multipliers of both paths
// (products registered at stages 2, 3, 5, 6 and 8)
// a stalled result holds only the stages behind it that are full; bubbles collapse
// reset clears the stage valid bits only, data registers are not reset
`include "julian_day_number_converter_top_defines.svh"
module julian_day_number_converter_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [4:0]         req_day_in,
   input  logic [3:0]         req_month_in,
   input  logic signed [14:0] req_year_in,
   input  logic [22:0]        req_day_number_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [22:0]        rsp_day_number_out,
   output logic [4:0]         rsp_day_out,
   output logic [3:0]         rsp_month_out,
   output logic signed [14:0] rsp_year_out
);
   import jdnc_pkg::*;

   logic [NumStages:1] valid_ff;
   logic [NumStages:1] valid_in;
   logic [NumStages:1] adv;

   // stage 1
   logic              s1_func_in, s1_func_ff;
   logic [4:0]        s1_d_in, s1_d_ff;
   logic [8:0]        s1_moff_in, s1_moff_ff;
   logic signed [15:0] s1_y_in, s1_y_ff;
   logic              s1_greg_in, s1_greg_ff;
   logic [23:0]       s1_a_in, s1_a_ff;
   // stage 2
   logic              s2_func_ff;
   logic [4:0]        s2_d_ff;
   logic [8:0]        s2_moff_ff;
   logic signed [25:0] s2_p365_in, s2_p365_ff;
   logic signed [13:0] s2_q4_in, s2_q4_ff;
   logic [13:0]       q4_biased;
   logic [11:0]       q16_biased;
   logic [26:0]       s2_pr100_in, s2_pr100_ff;
   logic [24:0]       s2_pr400_in, s2_pr400_ff;
   logic [52:0]       s2_bprod_in, s2_bprod_ff;
   logic              s2_greg_ff;
   logic [23:0]       s2_a_ff;
   // stage 3
   logic              s3_func_ff;
   logic signed [25:0] s3_base_in, s3_base_ff;
   logic signed [16:0] s3_corr_in, s3_corr_ff;
   logic [7:0]        cent;
   logic [25:0]       s3_bm_in, s3_bm_ff;
   logic [14:0]       s3_b100_in, s3_b100_ff;
   logic              s3_greg_ff;
   logic [23:0]       s3_a_ff;
   // stage 4
   logic              s4_func_ff;
   logic signed [25:0] jdn_greg, jdn_jul;
   logic [22:0]       s4_jdate_in, s4_jdate_ff;
   logic [21:0]       s4_c_in, s4_c_ff;
   logic [14:0]       s4_b100_ff;
   // stage 5
   logic              s5_func_ff;
   logic [22:0]       s5_jdate_ff;
   logic [47:0]       s5_dprod_in, s5_dprod_ff;
   logic [21:0]       s5_c_ff;
   logic [14:0]       s5_b100_ff;
   // stage 6
   logic              s6_func_ff;
   logic [22:0]       s6_jdate_ff;
   logic [12:0]       s6_dd_in, s6_dd_ff;
   logic [23:0]       s6_dm_in, s6_dm_ff;
   logic [21:0]       s6_c_ff;
   logic [14:0]       s6_b100_ff;
   // stage 7
   logic              s7_func_ff;
   logic [22:0]       s7_jdate_ff;
   logic [8:0]        s7_e_in, s7_e_ff;
   logic signed [15:0] s7_yb_in, s7_yb_ff;
   // stage 8
   logic              s8_func_ff;
   logic [22:0]       s8_jdate_ff;
   logic [8:0]        s8_e_ff;
   logic signed [15:0] s8_yb_ff;
   logic [10:0]       kx;
   logic [21:0]       s8_kprod_in, s8_kprod_ff;
   // stage 9, result registers
   logic [3:0]        kmon;
   logic              k_wrap;
   logic [22:0]       s9_jdn_in, s9_jdn_ff;
   logic [4:0]        s9_day_in, s9_day_ff;
   logic [3:0]        s9_mon_in, s9_mon_ff;
   logic [14:0]       s9_year_in, s9_year_ff;

   // a stage takes new contents when it is empty or the one after it moves
   always_comb begin
      adv[NumStages] = !valid_ff[NumStages] || rsp_ready;
      for (int i = NumStages - 1; i >= 1; i--) begin
         adv[i] = !valid_ff[i] || adv[i + 1];
      end
      valid_in[1] = adv[1] ? req_valid : valid_ff[1];
      for (int i = 2; i <= NumStages; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i - 1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[1];
   assign rsp_valid = valid_ff[NumStages];

   // stage 1: month table, shifted year, calendar choice
   always_comb begin
      s1_func_in = req_func;
      s1_d_in    = req_day_in;
      s1_moff_in = mar_offset(month_to_mar(req_month_in));
      s1_y_in    = $signed({req_year_in[14], req_year_in})
                 + $signed({3'b000, year_bias(req_month_in)});
      s1_greg_in = req_day_number_in > GregLastJul;
      s1_a_in    = {1'b0, req_day_number_in} + 24'(GregShift);
   end

   // stage 2: multiplies
   always_comb begin
      s2_p365_in  = 26'(s1_y_ff) * 26'sd365;
      s2_q4_in    = 14'(s1_y_ff >>> 2);
      q4_biased   = s2_q4_in + 14'(Q100Bias * 25);
      q16_biased  = 12'(s1_y_ff >>> 4) + 12'(Q400Bias * 25);
      s2_pr100_in = 27'(q4_biased) * 27'(Recip25);
      s2_pr400_in = 25'(q16_biased) * 25'(Recip25);
      s2_bprod_in = 53'({s1_a_ff, 2'b11}) * 53'(Recip146097);
   end

   // stage 3: day sum and century correction, centuries of the gregorian path
   always_comb begin
      s3_base_in = s2_p365_ff + 26'(s2_q4_ff) + $signed({21'b0, s2_d_ff})
                 + $signed({17'b0, s2_moff_ff});
      s3_corr_in = $signed({10'b0, s2_pr400_ff[Recip25Shift + 6:Recip25Shift]})
                 - $signed({8'b0, s2_pr100_ff[Recip25Shift + 8:Recip25Shift]})
                 - 17'(GregOffset + Q400Bias - Q100Bias);
      cent       = s2_greg_ff ? s2_bprod_ff[51:44] : 8'd0;
      s3_bm_in   = 26'(cent) * 26'(DaysPer400);
      s3_b100_in = 15'(cent) * 15'd100;
   end

   // stage 4: calendar pick for the day number, day within the century
   always_comb begin
      jdn_greg    = s3_base_ff + 26'(s3_corr_ff);
      jdn_jul     = s3_base_ff - 26'(JulOffset);
      s4_jdate_in = (jdn_greg < 26'(GregFirstJdn)) ? jdn_jul[22:0] : jdn_greg[22:0];
      s4_c_in     = s3_greg_ff ? 22'(s3_a_ff - s3_bm_ff[25:2])
                               : 22'(s3_a_ff + 24'(JulShift - GregShift));
   end

   // stage 5: year count from the day within the century
   assign s5_dprod_in = 48'({s4_c_ff, 2'b11}) * 48'(Recip1461);

   // stage 6
   always_comb begin
      s6_dd_in = s5_dprod_ff[46:34];
      s6_dm_in = 24'(s6_dd_in) * 24'(DaysPer4);
   end

   // stage 7: day of the march-based year, year before the month carry
   always_comb begin
      s7_e_in  = 9'(s6_c_ff - s6_dm_ff[23:2]);
      s7_yb_in = $signed({1'b0, s6_b100_ff}) + $signed({3'b000, s6_dd_ff})
               - 16'(YearBias);
   end

   // stage 8: month from march
   always_comb begin
      kx          = {s7_e_ff, 2'b00} + 11'(s7_e_ff) + 11'd2;
      s8_kprod_in = 22'(kx) * 22'(Recip153);
   end

   // stage 9: final fields, the unused direction is zero
   always_comb begin
      kmon   = s8_kprod_ff[21:18];
      k_wrap = kmon >= 4'd10;
      if (s8_func_ff) begin
         s9_jdn_in  = '0;
         s9_day_in  = 5'(s8_e_ff - mar_offset(kmon) + 9'd1);
         s9_mon_in  = k_wrap ? kmon - 4'd9 : kmon + 4'd3;
         s9_year_in = s8_yb_ff[14:0] + {14'b0, k_wrap};
      end else begin
         s9_jdn_in  = s8_jdate_ff;
         s9_day_in  = '0;
         s9_mon_in  = '0;
         s9_year_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_func_ff <= s1_func_in;
         s1_d_ff    <= s1_d_in;
         s1_moff_ff <= s1_moff_in;
         s1_y_ff    <= s1_y_in;
         s1_greg_ff <= s1_greg_in;
         s1_a_ff    <= s1_a_in;
      end
      if (adv[2]) begin
         s2_func_ff  <= s1_func_ff;
         s2_d_ff     <= s1_d_ff;
         s2_moff_ff  <= s1_moff_ff;
         s2_p365_ff  <= s2_p365_in;
         s2_q4_ff    <= s2_q4_in;
         s2_pr100_ff <= s2_pr100_in;
         s2_pr400_ff <= s2_pr400_in;
         s2_bprod_ff <= s2_bprod_in;
         s2_greg_ff  <= s1_greg_ff;
         s2_a_ff     <= s1_a_ff;
      end
      if (adv[3]) begin
         s3_func_ff <= s2_func_ff;
         s3_base_ff <= s3_base_in;
         s3_corr_ff <= s3_corr_in;
         s3_bm_ff   <= s3_bm_in;
         s3_b100_ff <= s3_b100_in;
         s3_greg_ff <= s2_greg_ff;
         s3_a_ff    <= s2_a_ff;
      end
      if (adv[4]) begin
         s4_func_ff  <= s3_func_ff;
         s4_jdate_ff <= s4_jdate_in;
         s4_c_ff     <= s4_c_in;
         s4_b100_ff  <= s3_b100_ff;
      end
      if (adv[5]) begin
         s5_func_ff  <= s4_func_ff;
         s5_jdate_ff <= s4_jdate_ff;
         s5_dprod_ff <= s5_dprod_in;
         s5_c_ff     <= s4_c_ff;
         s5_b100_ff  <= s4_b100_ff;
      end
      if (adv[6]) begin
         s6_func_ff  <= s5_func_ff;
         s6_jdate_ff <= s5_jdate_ff;
         s6_dd_ff    <= s6_dd_in;
         s6_dm_ff    <= s6_dm_in;
         s6_c_ff     <= s5_c_ff;
         s6_b100_ff  <= s5_b100_ff;
      end
      if (adv[7]) begin
         s7_func_ff  <= s6_func_ff;
         s7_jdate_ff <= s6_jdate_ff;
         s7_e_ff     <= s7_e_in;
         s7_yb_ff    <= s7_yb_in;
      end
      if (adv[8]) begin
         s8_func_ff  <= s7_func_ff;
         s8_jdate_ff <= s7_jdate_ff;
         s8_e_ff     <= s7_e_ff;
         s8_yb_ff    <= s7_yb_ff;
         s8_kprod_ff <= s8_kprod_in;
      end
      if (adv[9]) begin
         s9_jdn_ff  <= s9_jdn_in;
         s9_day_ff  <= s9_day_in;
         s9_mon_ff  <= s9_mon_in;
         s9_year_ff <= s9_year_in;
      end
   end

   assign rsp_day_number_out = s9_jdn_ff;
   assign rsp_day_out        = s9_day_ff;
   assign rsp_month_out      = s9_mon_ff;
   assign rsp_year_out       = $signed(s9_year_ff);

   `JDNC_ASSERT_NXT(a_accept_fills_stage, req_valid && req_ready, valid_ff[1],
      "accepted item lost at entry")
   `JDNC_ASSERT_IMP(a_day_in_year, valid_ff[8], s8_e_ff <= 9'd365,
      "day of year out of range")
   `JDNC_ASSERT_IMP(a_month_index, valid_ff[8], s8_kprod_ff[21:18] <= 4'd11,
      "month index out of range")
   `JDNC_ASSERT_IMP(a_month_out, rsp_valid, rsp_month_out <= 4'd12,
      "result month out of range")
   `JDNC_ASSERT_IMP(a_one_direction, rsp_valid,
      (rsp_day_number_out == '0) ||
      ((rsp_day_out == '0) && (rsp_month_out == '0) && (rsp_year_out == '0)),
      "both directions drive result fields")

endmodule
